// ===== rtl/idnt_pkg.sv =====
`default_nettype none

package idnt_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int ID_W         = 24;
    localparam int WORD_W       = 64;
    localparam int NAME_BYTES   = 24;
    localparam int SLOT_W       = 5;
    localparam int COUNT_W      = 6;

    localparam logic [COUNT_W-1:0] LIST_LIMIT = 6'd32;

    localparam logic [1:0] ACT_SET     = 2'd0;
    localparam logic [1:0] ACT_BY_ID   = 2'd1;
    localparam logic [1:0] ACT_BY_NAME = 2'd2;
    localparam logic [1:0] ACT_LIST    = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_UNDEF    = 2'd3;

    typedef logic [2:0][WORD_W-1:0] t_name;

    typedef struct packed {
        logic [ID_W-1:0] id;
        t_name           name;
    } t_entry;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        t_name             name;
        logic              last;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

    // zero every byte after the first zero byte
    function automatic t_name trim_name(input t_name w);
        logic [NAME_BYTES*8-1:0] flat;
        logic [NAME_BYTES*8-1:0] res;
        logic [NAME_BYTES-1:0]   nz;
        logic [NAME_BYTES-1:0]   below;
        logic                    keep;
        flat = w;
        for (int k = 0; k < NAME_BYTES; k++) begin
            nz[k] = |flat[8*k +: 8];
        end
        for (int k = 0; k < NAME_BYTES; k++) begin
            below = (NAME_BYTES'(1) << k) - NAME_BYTES'(1);
            keep  = &(nz | ~below);
            res[8*k +: 8] = keep ? flat[8*k +: 8] : 8'h00;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/idnt_cell.sv =====
`default_nettype none

module idnt_cell (
    input  wire             i_clk,
    input  wire             i_shift,
    input  idnt_pkg::t_entry i_d,
    output idnt_pkg::t_entry o_q
);

    idnt_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== rtl/id_name_associative_table.sv =====
`default_nettype none

// channel   | handshake          | payload
// ----------+--------------------+----------------------------------------------
// request   | i_valid / o_stall  | i_action i_target_id i_name_word0..2
//           |                    | i_max_count
// result    | o_valid / i_stall  | o_status o_slot_index o_found_id
//           |                    | o_found_name0..2 o_last
//
// each transaction is taken in idle, makes one full rotation of the entry ring of CAPACITY
// cells, and then posts the final result from the flush state.
// a set with id 0 skips the rotation.
// reset clears the controller and the fill count; entries are not cleared.
// a result stall holds the ring while a list walk has a hit waiting to go out.

module id_name_associative_table #(
    parameter int CAPACITY = idnt_pkg::DEF_CAPACITY
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  [1:0]                      i_action,
    input  wire  [idnt_pkg::ID_W-1:0]       i_target_id,
    input  wire  [idnt_pkg::WORD_W-1:0]     i_name_word0,
    input  wire  [idnt_pkg::WORD_W-1:0]     i_name_word1,
    input  wire  [idnt_pkg::WORD_W-1:0]     i_name_word2,
    input  wire  [idnt_pkg::COUNT_W-1:0]    i_max_count,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic [1:0]                      o_status,
    output logic [idnt_pkg::SLOT_W-1:0]     o_slot_index,
    output logic [idnt_pkg::ID_W-1:0]       o_found_id,
    output logic [idnt_pkg::WORD_W-1:0]     o_found_name0,
    output logic [idnt_pkg::WORD_W-1:0]     o_found_name1,
    output logic [idnt_pkg::WORD_W-1:0]     o_found_name2,
    output logic                            o_last
);

    localparam int IW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    idnt_pkg::t_state                r_state, n_state;
    logic [IW-1:0]                   r_step;
    logic [FW-1:0]                   r_fill;
    logic [1:0]                      r_act;
    logic [idnt_pkg::ID_W-1:0]       r_id;
    idnt_pkg::t_name                 r_key;
    logic [idnt_pkg::COUNT_W-1:0]    r_maxc;
    logic [idnt_pkg::COUNT_W-1:0]    r_cnt;
    logic                            r_hit;
    logic                            r_pend_valid;
    idnt_pkg::t_result               r_pend;
    logic [1:0]                      r_fail;
    logic                            r_out_valid;
    idnt_pkg::t_result               r_out;

    idnt_pkg::t_entry                cell_q [CAPACITY];
    idnt_pkg::t_entry                head;
    idnt_pkg::t_entry                tail_d;

    logic                            accept;
    logic                            adv;
    logic                            set_wr;
    logic                            app;
    logic                            take;
    logic                            emit_mid;
    logic                            emit_final;
    logic                            out_free;
    logic                            in_fill;
    logic                            id_eq;
    logic                            name_eq;
    logic                            last_step;
    logic [IW+idnt_pkg::SLOT_W-1:0]  step_ext;
    logic [idnt_pkg::SLOT_W-1:0]     slot;
    logic [idnt_pkg::COUNT_W-1:0]    in_maxc;
    idnt_pkg::t_name                 in_key;

    // ring of entry cells, cell 0 is the head
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        idnt_pkg::t_entry d;
        if (k == CAPACITY - 1) begin : g_tail
            assign d = tail_d;
        end else begin : g_mid
            assign d = cell_q[k+1];
        end
        idnt_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (adv),
            .i_d     (d),
            .o_q     (cell_q[k])
        );
    end

    assign head      = cell_q[0];
    assign in_fill   = FW'(r_step) < r_fill;
    assign id_eq     = head.id == r_id;
    assign name_eq   = head.name == r_key;
    assign out_free  = !r_out_valid || !i_stall;
    assign last_step = r_step == IW'(CAPACITY - 1);
    assign step_ext  = (IW + idnt_pkg::SLOT_W)'(r_step);
    assign slot      = step_ext[idnt_pkg::SLOT_W-1:0];
    assign in_key    = idnt_pkg::trim_name({i_name_word2, i_name_word1, i_name_word0});
    assign in_maxc   = (i_max_count == '0) ? idnt_pkg::COUNT_W'(1) :
                       (i_max_count > idnt_pkg::LIST_LIMIT) ? idnt_pkg::LIST_LIMIT :
                       i_max_count;
    assign tail_d    = set_wr ? idnt_pkg::t_entry'{id: r_id, name: r_key} : head;

    always_comb begin
        n_state = r_state;
        case (r_state)
            idnt_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_action == idnt_pkg::ACT_SET && i_target_id == '0) begin
                        n_state = idnt_pkg::ST_FLUSH;
                    end else begin
                        n_state = idnt_pkg::ST_WALK;
                    end
                end
            end
            idnt_pkg::ST_WALK: begin
                if (adv && last_step) begin
                    n_state = idnt_pkg::ST_FLUSH;
                end
            end
            idnt_pkg::ST_FLUSH: begin
                if (out_free) begin
                    n_state = idnt_pkg::ST_IDLE;
                end
            end
            default: n_state = idnt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall    = 1'b1;
        accept     = 1'b0;
        adv        = 1'b0;
        set_wr     = 1'b0;
        app        = 1'b0;
        take       = 1'b0;
        emit_mid   = 1'b0;
        emit_final = 1'b0;
        case (r_state)
            idnt_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                accept  = i_valid;
            end
            idnt_pkg::ST_WALK: begin
                adv = 1'b1;
                case (r_act)
                    idnt_pkg::ACT_SET: begin
                        app    = !r_hit && FW'(r_step) == r_fill;
                        set_wr = !r_hit && ((in_fill && id_eq) || app);
                    end
                    idnt_pkg::ACT_BY_ID: begin
                        take = !r_hit && in_fill && id_eq;
                    end
                    idnt_pkg::ACT_BY_NAME: begin
                        take = !r_hit && in_fill && name_eq;
                    end
                    idnt_pkg::ACT_LIST: begin
                        if (!r_hit && in_fill && name_eq) begin
                            if (r_pend_valid) begin
                                emit_mid = out_free;
                                take     = out_free;
                                adv      = out_free;
                            end else begin
                                take = 1'b1;
                            end
                        end
                    end
                    default: adv = 1'b1;
                endcase
            end
            idnt_pkg::ST_FLUSH: begin
                emit_final = out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= idnt_pkg::ST_IDLE;
            r_step       <= '0;
            r_fill       <= '0;
            r_hit        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_step       <= '0;
                r_hit        <= 1'b0;
                r_pend_valid <= 1'b0;
                r_cnt        <= '0;
            end
            if (adv) begin
                r_step <= last_step ? '0 : r_step + IW'(1);
            end
            if (app) begin
                r_fill <= r_fill + FW'(1);
            end
            if (set_wr) begin
                r_hit        <= 1'b1;
                r_pend_valid <= 1'b1;
            end
            if (take) begin
                r_pend_valid <= 1'b1;
                r_cnt        <= r_cnt + idnt_pkg::COUNT_W'(1);
                if (r_act != idnt_pkg::ACT_LIST ||
                    r_cnt + idnt_pkg::COUNT_W'(1) == r_maxc) begin
                    r_hit <= 1'b1;
                end
            end
            if (emit_mid || emit_final) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_action;
            r_id   <= i_target_id;
            r_key  <= in_key;
            r_maxc <= in_maxc;
            if (i_action == idnt_pkg::ACT_SET) begin
                r_fail <= (i_target_id == '0) ? idnt_pkg::STAT_UNDEF : idnt_pkg::STAT_FULL;
            end else begin
                r_fail <= idnt_pkg::STAT_NOTFOUND;
            end
        end
        if (set_wr) begin
            r_pend <= '{status: idnt_pkg::STAT_OK, slot: slot, id: r_id, name: r_key,
                        last: 1'b0};
        end
        if (take) begin
            r_pend <= '{status: idnt_pkg::STAT_OK, slot: slot, id: head.id, name: head.name,
                        last: 1'b0};
        end
        if (emit_mid) begin
            r_out <= '{status: r_pend.status, slot: r_pend.slot, id: r_pend.id,
                       name: r_pend.name, last: 1'b0};
        end
        if (emit_final) begin
            if (r_pend_valid) begin
                r_out <= '{status: r_pend.status, slot: r_pend.slot, id: r_pend.id,
                           name: r_pend.name, last: 1'b1};
            end else begin
                r_out <= '{status: r_fail, slot: '0, id: '0, name: '0, last: 1'b1};
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_slot_index  = r_out.slot;
    assign o_found_id    = r_out.id;
    assign o_found_name0 = r_out.name[0];
    assign o_found_name1 = r_out.name[1];
    assign o_found_name2 = r_out.name[2];
    assign o_last        = r_out.last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(CAPACITY))
        else $error("fill count above capacity");

    a_ring_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == idnt_pkg::ST_IDLE |-> r_step == '0)
        else $error("entry ring not aligned when idle");

    a_mid_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_mid |-> r_act == idnt_pkg::ACT_LIST && r_state == idnt_pkg::ST_WALK)
        else $error("non-final result outside a list walk");

    a_one_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        app |=> r_hit && !app)
        else $error("second append in one set");

endmodule

`default_nettype wire
